@@ rtl/core/lse_pkg.sv @@
`timescale 1ns / 1ps
// Package for the lexicographic subset enumerator: field widths, register
// indexes and default limits. No dependencies.
package lse_pkg;

    localparam int CNT_W       = 7;   // set_size, pick_count, member_count
    localparam int MASK_W      = 64;  // member_mask
    localparam int IN_DATA_W   = 8;   // restart, padded to a byte
    localparam int OUT_DATA_W  = 72;  // member_mask, member_count, padded
    localparam int OUT_USER_W  = 2;   // exhausted, bad_config
    localparam int CFG_IDX_W   = 1;

    localparam int DEF_MAX_SET  = 64;
    localparam int DEF_MAX_PICK = 64;

    localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PICK_COUNT = 1'b1;

    localparam logic [CNT_W-1:0] SET_SIZE_RST   = 7'd8;
    localparam logic [CNT_W-1:0] PICK_COUNT_RST = 7'd3;

endpackage

@@ rtl/core/lexicographic_subset_enumerator.sv @@
`timescale 1ns / 1ps
// Lexicographic k-combination generator, top level.
// Depends on lse_pkg.
//
// Each request transaction on the s_ side yields one result transaction on
// the m_ side. The current subset is held as a bit mask and is walked one
// bit per cycle by a single position pointer under a four-state sequencer.
// A restart (or the first request after reset or a register write) sweeps
// all MAX_SET mask bits. An advance scans down from bit n-1 past the top
// run of members to the next member b, then rewrites bits b..n-1. One
// request is in flight at a time; a finished result waits in the output
// register while the next request is taken.
module lexicographic_subset_enumerator
    import lse_pkg::*;
#(
    parameter int MAX_SET  = DEF_MAX_SET,
    parameter int MAX_PICK = DEF_MAX_PICK
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CNT_W-1:0]      cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [0] restart, [7:1] zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [63:0] member_mask, [70:64] member_count
    output logic                  m_tlast,   // last_subset
    output logic [OUT_USER_W-1:0] m_tuser    // [0] exhausted, [1] bad_config
);

    localparam int PW = $clog2(MAX_SET);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FILL = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [1:0] KIND_OK  = 2'd0;
    localparam logic [1:0] KIND_EXH = 2'd1;
    localparam logic [1:0] KIND_BAD = 2'd2;

    localparam logic [CNT_W-1:0] MAX_SET_C  = CNT_W'(MAX_SET);
    localparam logic [CNT_W-1:0] MAX_PICK_C = CNT_W'(MAX_PICK);

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    set_size_reg, pick_count_reg;
    logic                started_reg, finished_reg;
    logic [MAX_SET-1:0]  mask_reg;
    logic [PW-1:0]       ptr_reg;
    logic [PW-1:0]       end_reg;
    logic                run_reg;
    logic [CNT_W-1:0]    k_reg, lo_reg, hi_reg;
    logic                fin_reg;
    logic [1:0]          kind_reg;

    logic                m_valid_reg;
    logic [MASK_W-1:0]   out_mask_reg;
    logic [CNT_W-1:0]    out_count_reg;
    logic                out_last_reg;
    logic                out_exh_reg;
    logic                out_bad_reg;

    logic [CNT_W-1:0]    n_eff, r_eff, ptr_ext, fill_hi;
    logic [CNT_W:0]      top_sum;
    logic                bit_cur, fill_bit, in_acc, out_load, restart;

    assign n_eff    = (set_size_reg > MAX_SET_C) ? MAX_SET_C : set_size_reg;
    assign r_eff    = (pick_count_reg > MAX_PICK_C) ? MAX_PICK_C : pick_count_reg;
    assign ptr_ext  = CNT_W'(ptr_reg);
    assign bit_cur  = mask_reg[ptr_reg];
    assign fill_bit = (ptr_ext >= lo_reg) && (ptr_ext < hi_reg);
    assign fill_hi  = ptr_ext + k_reg + CNT_W'(2);
    assign top_sum  = {1'b0, ptr_ext} + {1'b0, k_reg} + (CNT_W+1)'(2);
    assign restart  = s_tdata[0];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    priority if (r_eff > n_eff)
                        state_next = ST_DONE;
                    else if (restart || !started_reg)
                        state_next = ST_FILL;
                    else if (finished_reg)
                        state_next = ST_DONE;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!run_reg && bit_cur)
                    state_next = ST_FILL;
            end
            ST_FILL:
            begin
                if (ptr_reg == end_reg)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            set_size_reg   <= SET_SIZE_RST;
            pick_count_reg <= PICK_COUNT_RST;
            started_reg    <= 1'b0;
            finished_reg   <= 1'b0;
            ptr_reg        <= '0;
            end_reg        <= '0;
            run_reg        <= 1'b0;
            k_reg          <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            fin_reg        <= 1'b0;
            kind_reg       <= KIND_OK;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_SET_SIZE:   set_size_reg   <= cfg_data;
                    REG_PICK_COUNT: pick_count_reg <= cfg_data;
                    default: ;
                endcase
                started_reg  <= 1'b0;
                finished_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        priority if (r_eff > n_eff)
                            kind_reg <= KIND_BAD;
                        else if (restart || !started_reg)
                        begin
                            kind_reg    <= KIND_OK;
                            started_reg <= 1'b1;
                            ptr_reg     <= '0;
                            end_reg     <= PW'(MAX_SET - 1);
                            lo_reg      <= '0;
                            hi_reg      <= r_eff;
                            fin_reg     <= (r_eff == n_eff) || (r_eff == '0);
                        end
                        else if (finished_reg)
                            kind_reg <= KIND_EXH;
                        else
                        begin
                            kind_reg <= KIND_OK;
                            ptr_reg  <= PW'(n_eff - CNT_W'(1));
                            end_reg  <= PW'(n_eff - CNT_W'(1));
                            run_reg  <= 1'b1;
                            k_reg    <= '0;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (run_reg)
                    begin
                        if (bit_cur)
                            k_reg <= k_reg + CNT_W'(1);
                        else
                            run_reg <= 1'b0;
                        ptr_reg <= ptr_reg - PW'(1);
                    end
                    else if (bit_cur)
                    begin
                        lo_reg  <= ptr_ext + CNT_W'(1);
                        hi_reg  <= fill_hi;
                        fin_reg <= (k_reg + CNT_W'(1) == r_eff) &&
                                   (top_sum == {1'b0, n_eff});
                    end
                    else
                        ptr_reg <= ptr_reg - PW'(1);
                end
                ST_FILL:
                begin
                    if (ptr_reg == end_reg)
                        finished_reg <= fin_reg;
                    else
                        ptr_reg <= ptr_reg + PW'(1);
                end
                ST_DONE: ;
                default: ;
            endcase

            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FILL)
            mask_reg[ptr_reg] <= fill_bit;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (kind_reg == KIND_OK)
            begin
                out_mask_reg  <= MASK_W'(mask_reg);
                out_count_reg <= r_eff;
                out_last_reg  <= finished_reg;
            end
            else
            begin
                out_mask_reg  <= '0;
                out_count_reg <= '0;
                out_last_reg  <= 1'b0;
            end
            out_exh_reg <= (kind_reg == KIND_EXH);
            out_bad_reg <= (kind_reg == KIND_BAD);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_mask_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_bad_reg, out_exh_reg};

    // subset results carry exactly member_count members
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == '0) |->
            ($countones(m_tdata[MASK_W-1:0]) == int'(m_tdata[MASK_W+CNT_W-1:MASK_W])))
        else $error("member count does not match mask");

    // error replies carry no subset
    a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != '0) |->
            (m_tdata[MASK_W-1:0] == '0) && !m_tlast)
        else $error("error reply with members or last flag");

    // the downward scan never leaves the ground set
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (ptr_ext < n_eff))
        else $error("scan pointer outside ground set");

    // a result is produced only after the sequencer finishes
    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside done state");

endmodule

@@ sim/lexicographic_subset_enumerator_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for lexicographic_subset_enumerator: directed and random
// request streams against an internal subset predictor, with random stalls on both sides.
// Depends on lse_pkg and the enumerator RTL.
module lexicographic_subset_enumerator_tb;
    import lse_pkg::*;

    localparam int MAX_SET          = DEF_MAX_SET;
    localparam int MAX_PICK         = DEF_MAX_PICK;
    localparam int ITEM_TARGET      = 950;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int DRAIN_CYCLES     = 2 * MAX_SET + 8;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic [CNT_W-1:0]  count;
        logic              last;
        logic              exhausted;
        logic              bad_cfg;
    } subset_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CNT_W-1:0]      cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic [OUT_USER_W-1:0] m_tuser;

    // predictor state
    logic [CNT_W-1:0] shadow_set_size = SET_SIZE_RST;
    logic [CNT_W-1:0] shadow_pick_count = PICK_COUNT_RST;
    logic [5:0]       cur_index [MAX_PICK] = '{default: '0};
    bit               enum_started = 1'b0;
    bit               enum_finished = 1'b0;

    subset_result_t   pending_subsets [$];
    int               requests_sent = 0;
    int               mismatch_count = 0;
    int               idle_cycles = 0;
    bit               src_quiet = 1'b0;
    bit               sink_quiet = 1'b0;
    bit               sink_hold = 1'b0;

    lexicographic_subset_enumerator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #4 clk = ~clk;

    function automatic int idle_gap(input bit quiet);
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // walks the sorted index list one step and builds the expected transaction
    function automatic subset_result_t next_subset(input logic restart);
        subset_result_t res;
        int n;
        int r;
        int pos;
        bit at_end;
        res = '0;
        n = (shadow_set_size > MAX_SET) ? MAX_SET : int'(shadow_set_size);
        r = (shadow_pick_count > MAX_PICK) ? MAX_PICK : int'(shadow_pick_count);
        if (r > n)
        begin
            res.bad_cfg = 1'b1;
            return res;
        end
        if (restart || !enum_started)
        begin
            for (int k = 0; k < r; k++)
                cur_index[k] = 6'(k);
            enum_started = 1'b1;
        end
        else if (enum_finished)
        begin
            res.exhausted = 1'b1;
            return res;
        end
        else
        begin
            pos = r - 1;
            while (pos > 0 && cur_index[pos] >= n - r + pos)
                pos--;
            cur_index[pos] = cur_index[pos] + 6'd1;
            for (int k = pos + 1; k < r; k++)
                cur_index[k] = cur_index[k-1] + 6'd1;
        end
        at_end = 1'b1;
        for (int k = 0; k < r; k++)
        begin
            if (cur_index[k] < n - r + k)
                at_end = 1'b0;
            res.mask[cur_index[k]] = 1'b1;
        end
        enum_finished = at_end;
        res.count = 7'(r);
        res.last = at_end;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic send_request(input logic restart);
        int gap;
        gap = idle_gap(src_quiet);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W-1){1'b0}}, restart};
        do @(posedge clk); while (!s_tready);
        pending_subsets.push_back(next_subset(restart));
        requests_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_subsets.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == REG_SET_SIZE)
            shadow_set_size = value;
        else
            shadow_pick_count = value;
        enum_started  = 1'b0;
        enum_finished = 1'b0;
    endtask

    task automatic set_config(input bit wr_set, input logic [CNT_W-1:0] n,
                              input bit wr_pick, input logic [CNT_W-1:0] r);
        drain_results();
        if (wr_set)
            write_reg(REG_SET_SIZE, n);
        if (wr_pick)
            write_reg(REG_PICK_COUNT, r);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
    endtask

    task automatic test_config_extremes();
        set_config(1'b1, 7'd64, 1'b1, 7'd64);
        send_request(1'b0);
        send_request(1'b0);
        set_config(1'b0, 7'd0, 1'b1, 7'd1);
        send_request(1'b0);
        send_request(1'b0);
        // empty pick on an empty set
        set_config(1'b1, 7'd0, 1'b1, 7'd0);
        send_request(1'b0);
        send_request(1'b0);
        set_config(1'b1, 7'd3, 1'b1, 7'd4);
        send_request(1'b0);
        // both registers above the parameter limits
        set_config(1'b1, 7'd127, 1'b1, 7'd127);
        send_request(1'b0);
        send_request(1'b1);
        set_config(1'b0, 7'd0, 1'b1, 7'd63);
        send_request(1'b0);
    endtask

    task automatic test_full_walk();
        set_config(1'b1, 7'd4, 1'b1, 7'd2);
        repeat (7) send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
    endtask

    task automatic test_output_backpressure();
        set_config(1'b1, 7'd6, 1'b1, 7'd3);
        src_quiet = 1'b1;
        sink_hold = 1'b1;
        repeat (8) send_request(1'b0);
        src_quiet = 1'b0;
        drain_results();
    endtask

    task automatic test_sender_pause();
        set_config(1'b1, 7'd7, 1'b1, 7'd2);
        repeat (5) send_request(1'b0);
        drain_results();
        repeat (5) send_request(1'b0);
    endtask

    task automatic test_back_to_back();
        set_config(1'b1, 7'd9, 1'b1, 7'd4);
        src_quiet  = 1'b1;
        sink_quiet = 1'b1;
        for (int k = 0; k < 30; k++)
            send_request($urandom_range(0, 15) == 0);
        src_quiet  = 1'b0;
        sink_quiet = 1'b0;
    endtask

    task automatic test_random_walks();
        int kind;
        int steps;
        int sel;
        logic [CNT_W-1:0] n;
        logic [CNT_W-1:0] r;
        while (requests_sent < ITEM_TARGET)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 60)
            begin
                n = CNT_W'($urandom_range(1, 10));
                r = CNT_W'($urandom_range(0, n));
                steps = $urandom_range(3, 45);
            end
            else if (kind < 72)
            begin
                n = CNT_W'($urandom_range(11, 64));
                case ($urandom_range(0, 3))
                    0: r = 7'd1;
                    1: r = n - 7'd1;
                    2: r = n;
                    default: r = CNT_W'($urandom_range(2, n));
                endcase
                steps = (r <= 1 || r >= n - 1) ? int'(n) + 2 : int'($urandom_range(2, 16));
            end
            else if (kind < 80)
            begin
                // pick count beyond set size
                n = CNT_W'($urandom_range(0, 63));
                r = CNT_W'($urandom_range(n + 1, 127));
                steps = $urandom_range(1, 4);
            end
            else if (kind < 88)
            begin
                n = CNT_W'($urandom_range(64, 127));
                r = $urandom_range(0, 1) ? CNT_W'($urandom_range(0, 3))
                                         : CNT_W'($urandom_range(60, 127));
                steps = $urandom_range(2, 10);
            end
            else
            begin
                n = CNT_W'($urandom_range(0, 3));
                r = CNT_W'($urandom_range(0, 3));
                steps = $urandom_range(2, 8);
            end
            sel = $urandom_range(0, 5);
            set_config(sel != 0, n, sel != 1, r);
            for (int k = 0; k < steps; k++)
                send_request(k == 0 ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 24) == 0));
        end
    endtask

    initial
    begin
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_SET_SIZE;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_config_extremes();
        test_full_walk();
        test_output_backpressure();
        test_sender_pause();
        test_back_to_back();
        test_random_walks();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // receiver side: random stalls, plus one long hold-off on request
    initial
    begin : sink_ctrl
        int gap;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (sink_hold)
            begin
                m_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge clk);
                sink_hold = 1'b0;
            end
            else
            begin
                gap = idle_gap(sink_quiet);
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        subset_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_subsets.size() == 0)
            begin
                $error("result transaction with nothing expected: mask %0h", m_tdata[63:0]);
                mismatch_count++;
            end
            else
            begin
                want = pending_subsets.pop_front();
                check_field("member_mask", want.mask, m_tdata[63:0]);
                check_field("member_count", 64'(want.count), 64'(m_tdata[70:64]));
                check_field("last_subset", 64'(want.last), 64'(m_tlast));
                check_field("exhausted", 64'(want.exhausted), 64'(m_tuser[0]));
                check_field("bad_config", 64'(want.bad_cfg), 64'(m_tuser[1]));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
